@@ design/lwa_pkg.sv @@
`default_nettype none

package lwa_pkg;

  localparam int C_W        = 17;
  localparam int A_W        = 24;
  localparam int K_W        = 25;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_COURANT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED   = 2'd1;

  localparam logic [1:0] PS_NONE = 2'd0;
  localparam logic [1:0] PS_ONE  = 2'd1;
  localparam logic [1:0] PS_MANY = 2'd2;

  localparam logic [1:0] OP_FLUX_DIFF      = 2'd0;
  localparam logic [1:0] OP_HALF_VALUE     = 2'd1;
  localparam logic [1:0] OP_HALF_FLUX_DIFF = 2'd2;
  localparam logic [1:0] OP_NEW_VALUE      = 2'd3;

  localparam logic [1:0] OUT_FIRST    = 2'd0;
  localparam logic [1:0] OUT_INTERIOR = 2'd1;
  localparam logic [1:0] OUT_LAST     = 2'd2;

  typedef struct packed {
    logic       in_load;
    logic       opnd_load;
    logic [1:0] op;
    logic       mul_step;
    logic       out_load;
    logic [1:0] out_sel;
    logic       commit;
    logic       commit_half;
  } lwa_cmd_t;

  typedef struct packed {
    logic out_free;
    logic mul_last;
    logic last;
  } lwa_status_t;

endpackage

`default_nettype wire

@@ design/lwa_in_if.sv @@
`default_nettype none

interface lwa_in_if #(parameter int SAMPLE_WIDTH = 32);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] u_sample;
  logic signed [SAMPLE_WIDTH-1:0] f_sample;
  logic                           is_last;

  modport source (output valid, output u_sample, output f_sample, output is_last,
                  input ready);
  modport sink (input valid, input u_sample, input f_sample, input is_last,
                output ready);
endinterface

`default_nettype wire

@@ design/lwa_out_if.sv @@
`default_nettype none

interface lwa_out_if #(parameter int SAMPLE_WIDTH = 32);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] u_new;
  logic signed [SAMPLE_WIDTH-1:0] f_new;
  logic                           is_boundary;
  logic                           last_out;

  modport source (output valid, output u_new, output f_new, output is_boundary,
                  output last_out, input ready);
  modport sink (input valid, input u_new, input f_new, input is_boundary,
                input last_out, output ready);
endinterface

`default_nettype wire

@@ design/lwa_cfg_if.sv @@
`default_nettype none

interface lwa_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [lwa_pkg::CFG_IDX_W-1:0]   index;
  logic [lwa_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ design/lax_wendroff_advection_step.sv @@
`default_nettype none

// Streams one time step of the two-step Lax-Wendroff scheme for linear
// advection: each input item is one grid point (u, f), and results lag by one
// point, with the point marked last giving two results unless it is also the
// first point of its sweep. Each interior point needs four dependent products,
// the second point of a sweep two, all sharing one 33 x 25 bit multiplier;
// each product is accumulated over NCH 32-bit chunks of its operand, where
// NCH = ceil(SAMPLE_WIDTH/32), and an operand-load step between products
// does the shifting, saturation and the next difference. Results sit in
// an output register, so a new point is taken while a result waits.
// Configuration (courant_ratio index 0, advection_speed index 1) is always
// ready and must be written only between sweeps or while idle.
module lax_wendroff_advection_step #(
  parameter int SAMPLE_WIDTH = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  lwa_in_if.sink    in_if,
  lwa_out_if.source out_if,
  lwa_cfg_if.sink   cfg_if
);
  import lwa_pkg::*;

  lwa_cmd_t    cmd;
  lwa_status_t status;
  logic        in_ready;

  assign in_if.ready  = in_ready;
  assign cfg_if.ready = 1'b1;

  lwa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  lwa_dpath #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .in_u         (in_if.u_sample),
    .in_f         (in_if.f_sample),
    .in_last      (in_if.is_last),
    .cfg_write    (cfg_if.valid),
    .cfg_index    (cfg_if.index),
    .cfg_data     (cfg_if.data),
    .out_valid    (out_if.valid),
    .out_ready    (out_if.ready),
    .out_u        (out_if.u_new),
    .out_f        (out_if.f_new),
    .out_boundary (out_if.is_boundary),
    .out_last     (out_if.last_out)
  );

endmodule

`default_nettype wire

@@ design/lwa_ctrl.sv @@
`default_nettype none

module lwa_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire lwa_pkg::lwa_status_t status,
  output lwa_pkg::lwa_cmd_t        cmd
);
  import lwa_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_OP1    = 4'd1;
  localparam logic [3:0] S_MUL1   = 4'd2;
  localparam logic [3:0] S_OP2    = 4'd3;
  localparam logic [3:0] S_MUL2   = 4'd4;
  localparam logic [3:0] S_OP3    = 4'd5;
  localparam logic [3:0] S_MUL3   = 4'd6;
  localparam logic [3:0] S_OP4    = 4'd7;
  localparam logic [3:0] S_MUL4   = 4'd8;
  localparam logic [3:0] S_EMIT1  = 4'd9;
  localparam logic [3:0] S_COMMIT = 4'd10;
  localparam logic [3:0] S_EMITL  = 4'd11;

  logic [3:0] state_r, state_nxt;
  logic [1:0] ps_r, ps_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    ps_nxt    = ps_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.in_load = 1'b1;
          state_nxt   = (ps_r == PS_NONE) ? S_COMMIT : S_OP1;
        end
      end
      S_OP1: begin
        cmd.opnd_load = 1'b1;
        cmd.op        = OP_FLUX_DIFF;
        state_nxt     = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul_step = 1'b1;
        if (status.mul_last) state_nxt = S_OP2;
      end
      S_OP2: begin
        cmd.opnd_load = 1'b1;
        cmd.op        = OP_HALF_VALUE;
        state_nxt     = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul_step = 1'b1;
        if (status.mul_last) state_nxt = S_OP3;
      end
      S_OP3: begin
        cmd.opnd_load = 1'b1;
        cmd.op        = OP_HALF_FLUX_DIFF;
        state_nxt     = (ps_r == PS_ONE) ? S_EMIT1 : S_MUL3;
      end
      S_MUL3: begin
        cmd.mul_step = 1'b1;
        if (status.mul_last) state_nxt = S_OP4;
      end
      S_OP4: begin
        cmd.opnd_load = 1'b1;
        cmd.op        = OP_NEW_VALUE;
        state_nxt     = S_MUL4;
      end
      S_MUL4: begin
        cmd.mul_step = 1'b1;
        if (status.mul_last) state_nxt = S_EMIT1;
      end
      S_EMIT1: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = (ps_r == PS_ONE) ? OUT_FIRST : OUT_INTERIOR;
          state_nxt    = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.commit      = 1'b1;
        cmd.commit_half = (ps_r != PS_NONE);
        if (status.last) begin
          ps_nxt    = PS_NONE;
          state_nxt = S_EMITL;
        end else begin
          ps_nxt    = (ps_r == PS_NONE) ? PS_ONE : PS_MANY;
          state_nxt = S_IDLE;
        end
      end
      S_EMITL: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = OUT_LAST;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ps_r    <= PS_NONE;
    end else begin
      state_r <= state_nxt;
      ps_r    <= ps_nxt;
    end
  end

endmodule

`default_nettype wire

@@ design/lwa_dpath.sv @@
`default_nettype none

module lwa_dpath #(
  parameter int SAMPLE_WIDTH = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire lwa_pkg::lwa_cmd_t                   cmd,
  output lwa_pkg::lwa_status_t                     status,
  input  wire logic signed [SAMPLE_WIDTH-1:0]      in_u,
  input  wire logic signed [SAMPLE_WIDTH-1:0]      in_f,
  input  wire logic                                in_last,
  input  wire logic                                cfg_write,
  input  wire logic [lwa_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [lwa_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]           out_u,
  output logic signed [SAMPLE_WIDTH-1:0]           out_f,
  output logic                                     out_boundary,
  output logic                                     out_last
);
  import lwa_pkg::*;

  localparam int W     = SAMPLE_WIDTH;
  localparam int CW    = 32;
  localparam int NCH   = (W + CW - 1) / CW;
  localparam int XW    = NCH * CW;
  localparam int PW    = XW + K_W;
  localparam int CNT_W = (NCH > 1) ? $clog2(NCH) : 1;

  localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

  logic [C_W-1:0]          c_r;
  logic signed [A_W-1:0]   a_r;

  logic signed [W-1:0]     u_r, f_r, pv_r, pf_r, phf_r, hf_r, un_r, avg_r, opnd_r;
  logic                    last_r;
  logic signed [K_W-1:0]   k_r;
  logic                    sh17_r;
  logic signed [PW-1:0]    acc_r;
  logic [CNT_W-1:0]        cnt_r;
  logic                    out_valid_r;

  logic signed [XW-1:0]    xe;
  logic [CW-1:0]           chunk;
  logic                    top_chunk;
  logic signed [CW:0]      chunk_ext;
  logic signed [CW+K_W:0]  pp;
  logic signed [PW-1:0]    ppx;
  logic signed [W-1:0]     prod_sat;
  logic signed [W-1:0]     avg_w;
  logic signed [W:0]       avg_sum;
  logic signed [W-1:0]     hf_w, un_w;

  function automatic logic signed [W-1:0] sat_sub(input logic signed [W-1:0] x,
                                                  input logic signed [W-1:0] y);
    logic signed [W:0] d;
    d = {x[W-1], x} - {y[W-1], y};
    if (d[W] != d[W-1]) return d[W] ? SMIN : SMAX;
    return d[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] scale_sat(input logic signed [PW-1:0] v,
                                                    input logic sh17);
    logic signed [PW-1:0] s;
    logic [PW-W:0]        hi;
    s  = sh17 ? (v >>> 17) : (v >>> 16);
    hi = s[PW-1:W-1];
    if ((&hi) || !(|hi)) return s[W-1:0];
    return s[PW-1] ? SMIN : SMAX;
  endfunction

  always_comb begin
    xe        = XW'(opnd_r);
    chunk     = xe[cnt_r*CW +: CW];
    top_chunk = (cnt_r == CNT_W'(NCH - 1));
    chunk_ext = {top_chunk & chunk[CW-1], chunk};
    pp        = chunk_ext * k_r;
    ppx       = PW'(pp) <<< (CW * cnt_r);
    prod_sat  = scale_sat(acc_r, sh17_r);
    avg_sum   = {pv_r[W-1], pv_r} + {u_r[W-1], u_r};
    avg_w     = avg_sum[W:1];
    hf_w      = prod_sat;
    un_w      = sat_sub(pv_r, prod_sat);
  end

  assign status.out_free = !out_valid_r || out_ready;
  assign status.mul_last = top_chunk;
  assign status.last     = last_r;
  assign out_valid       = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_r <= C_W'(32768);
      a_r <= A_W'(65536);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_COURANT: c_r <= cfg_data[C_W-1:0];
        REG_SPEED:   a_r <= cfg_data[A_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      u_r    <= in_u;
      f_r    <= in_f;
      last_r <= in_last;
    end
    if (cmd.opnd_load) begin
      acc_r <= '0;
      cnt_r <= '0;
      case (cmd.op)
        OP_FLUX_DIFF: begin
          opnd_r <= sat_sub(f_r, pf_r);
          avg_r  <= avg_w;
          k_r    <= K_W'({1'b0, c_r});
          sh17_r <= 1'b1;
        end
        OP_HALF_VALUE: begin
          opnd_r <= sat_sub(avg_r, prod_sat);
          k_r    <= K_W'(a_r);
          sh17_r <= 1'b0;
        end
        OP_HALF_FLUX_DIFF: begin
          hf_r   <= hf_w;
          opnd_r <= sat_sub(hf_w, phf_r);
          k_r    <= K_W'({1'b0, c_r});
          sh17_r <= 1'b0;
        end
        OP_NEW_VALUE: begin
          un_r   <= un_w;
          opnd_r <= un_w;
          k_r    <= K_W'(a_r);
          sh17_r <= 1'b0;
        end
        default: ;
      endcase
    end else if (cmd.mul_step) begin
      acc_r <= acc_r + ppx;
      cnt_r <= cnt_r + CNT_W'(1);
    end
    if (cmd.commit) begin
      pv_r <= u_r;
      pf_r <= f_r;
      if (cmd.commit_half) phf_r <= hf_r;
    end
    if (cmd.out_load) begin
      case (cmd.out_sel)
        OUT_FIRST: begin
          out_u        <= pv_r;
          out_f        <= pf_r;
          out_boundary <= 1'b1;
          out_last     <= 1'b0;
        end
        OUT_INTERIOR: begin
          out_u        <= un_r;
          out_f        <= prod_sat;
          out_boundary <= 1'b0;
          out_last     <= 1'b0;
        end
        default: begin
          out_u        <= u_r;
          out_f        <= f_r;
          out_boundary <= 1'b1;
          out_last     <= 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

endmodule

`default_nettype wire

@@ dv/tb_lax_wendroff_advection_step.sv @@
module tb_lax_wendroff_advection_step;
  timeunit 1ns;
  timeprecision 1ps;

  import lwa_pkg::*;

  localparam int     SW            = 32;
  localparam longint SMAX          = (longint'(1) <<< (SW - 1)) - 1;
  localparam longint SMIN          = -SMAX - 1;
  localparam int     GAP_MAX       = 13;
  localparam int     DRAIN_CYCLES  = 32;
  localparam int     RANDOM_POINTS = 1550;
  localparam longint CYCLE_LIMIT   = 1000000;

  localparam logic [CFG_IDX_W-1:0]  REG_SPARE   = 2'd3;
  localparam logic [CFG_DATA_W-1:0] COURANT_MAX = 24'h01FFFF;
  localparam logic [CFG_DATA_W-1:0] COURANT_RST = 24'd32768;
  localparam logic [CFG_DATA_W-1:0] SPEED_MIN   = 24'h800000;
  localparam logic [CFG_DATA_W-1:0] SPEED_MAX   = 24'h7FFFFF;
  localparam logic [CFG_DATA_W-1:0] SPEED_RST   = 24'd65536;

  typedef logic signed [SW-1:0] sample_t;

  localparam sample_t S_MAX = sample_t'(SMAX);
  localparam sample_t S_MIN = sample_t'(SMIN);

  typedef struct packed {
    sample_t u_new;
    sample_t f_new;
    logic    is_boundary;
    logic    last_out;
  } grid_res_t;

  typedef enum logic {ROW_CFG, ROW_POINT} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    sample_t               u;
    sample_t               f;
    logic                  last;
    bit                    typed;
    int                    n_typed;
    grid_res_t             r0;
    grid_res_t             r1;
  } stim_row_t;

  logic clk;
  logic rst_n;

  lwa_in_if  #(.SAMPLE_WIDTH(SW)) in_bus ();
  lwa_out_if #(.SAMPLE_WIDTH(SW)) out_bus ();
  lwa_cfg_if                      cfg_bus ();

  lax_wendroff_advection_step #(.SAMPLE_WIDTH(SW)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_bus),
    .out_if (out_bus),
    .cfg_if (cfg_bus)
  );

  logic [C_W-1:0]        courant;
  logic signed [A_W-1:0] speed;
  sample_t               prev_u;
  sample_t               prev_f;
  sample_t               prev_hf;
  logic [1:0]            pts;

  grid_res_t pending_pts[$];
  stim_row_t stim_table[$];
  int        fails  = 0;
  longint    cycles = 0;
  bit        in_up  = 1'b0;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic sample_t clamp(input longint v);
    if (v > SMAX) return S_MAX;
    if (v < SMIN) return S_MIN;
    return sample_t'(v);
  endfunction

  function automatic sample_t scale_floor(input sample_t x, input longint k, input int s);
    longint p;
    p = longint'(x) * k;
    return clamp(p >>> s);
  endfunction

  function automatic sample_t diff_sat(input sample_t a, input sample_t b);
    return clamp(longint'(a) - longint'(b));
  endfunction

  function automatic sample_t mid_floor(input sample_t a, input sample_t b);
    return sample_t'((longint'(a) + longint'(b)) >>> 1);
  endfunction

  function automatic int advance_grid(input sample_t u, input sample_t f, input logic last,
                                      output grid_res_t res[2]);
    longint  c;
    longint  a;
    sample_t hu;
    sample_t hf;
    sample_t un;
    int      n;
    c      = longint'(courant);
    a      = longint'(speed);
    n      = 0;
    res[0] = '0;
    res[1] = '0;
    if (pts != PS_NONE) begin
      hu = diff_sat(mid_floor(prev_u, u), scale_floor(diff_sat(f, prev_f), c, 17));
      hf = scale_floor(hu, a, 16);
      if (pts == PS_ONE) begin
        res[n] = '{prev_u, prev_f, 1'b1, 1'b0};
      end else begin
        un     = diff_sat(prev_u, scale_floor(diff_sat(hf, prev_hf), c, 16));
        res[n] = '{un, scale_floor(un, a, 16), 1'b0, 1'b0};
      end
      n++;
      prev_hf = hf;
      pts     = PS_MANY;
    end else begin
      pts = PS_ONE;
    end
    prev_u = u;
    prev_f = f;
    if (last) begin
      res[n] = '{u, f, 1'b1, 1'b1};
      n++;
      pts = PS_NONE;
    end
    return n;
  endfunction

  function automatic void add_point(input sample_t u, input sample_t f, input logic last);
    stim_row_t r;
    r      = '{kind: ROW_POINT, default: '0};
    r.u    = u;
    r.f    = f;
    r.last = last;
    stim_table.push_back(r);
  endfunction

  function automatic void add_typed(input sample_t u, input sample_t f, input logic last,
                                    input int n, input grid_res_t r0, input grid_res_t r1);
    stim_row_t r;
    r         = '{kind: ROW_POINT, default: '0};
    r.u       = u;
    r.f       = f;
    r.last    = last;
    r.typed   = 1'b1;
    r.n_typed = n;
    r.r0      = r0;
    r.r1      = r1;
    stim_table.push_back(r);
  endfunction

  function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
    stim_row_t r;
    r      = '{kind: ROW_CFG, default: '0};
    r.idx  = idx;
    r.data = data;
    stim_table.push_back(r);
  endfunction

  function automatic sample_t pick_extreme();
    case ($urandom_range(0, 4))
      0: return S_MAX;
      1: return S_MIN;
      2: return sample_t'(0);
      3: return sample_t'(-1);
      default: return sample_t'(1);
    endcase
  endfunction

  task automatic flag_error(input string msg);
    fails++;
    $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  task automatic idle_input();
    if (in_up) begin
      in_bus.valid <= 1'b0;
      in_up = 1'b0;
    end
  endtask

  task automatic wait_results();
    idle_input();
    do @(posedge clk); while (pending_pts.size() != 0);
  endtask

  task automatic settle();
    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_point(input sample_t u, input sample_t f, input logic last,
                            input int gap);
    if (gap > 0) begin
      idle_input();
      repeat (gap) @(posedge clk);
    end
    in_bus.valid    <= 1'b1;
    in_bus.u_sample <= u;
    in_bus.f_sample <= f;
    in_bus.is_last  <= last;
    in_up = 1'b1;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      REG_COURANT: courant = val[C_W-1:0];
      REG_SPEED:   speed = val[A_W-1:0];
      default: ;
    endcase
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_point(input sample_t u, input sample_t f, input logic last);
    grid_res_t res[2];
    int        n;
    n = advance_grid(u, f, last, res);
    for (int k = 0; k < n; k++) pending_pts.push_back(res[k]);
  endtask

  always @(posedge clk) begin : check_results
    grid_res_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_pts.size() == 0) begin
        flag_error($sformatf("unexpected item u=%h f=%h", out_bus.u_new, out_bus.f_new));
      end else begin
        want = pending_pts.pop_front();
        if (out_bus.u_new !== want.u_new)
          flag_error($sformatf("u_new %h, want %h", out_bus.u_new, want.u_new));
        if (out_bus.f_new !== want.f_new)
          flag_error($sformatf("f_new %h, want %h", out_bus.f_new, want.f_new));
        if (out_bus.is_boundary !== want.is_boundary)
          flag_error($sformatf("is_boundary %b, want %b", out_bus.is_boundary,
                               want.is_boundary));
        if (out_bus.last_out !== want.last_out)
          flag_error($sformatf("last_out %b, want %b", out_bus.last_out, want.last_out));
      end
    end
  end

  initial begin : drain_results
    int gap;
    int calm;
    out_bus.ready <= 1'b0;
    calm = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (calm > 0) begin
        gap = 0;
        calm--;
      end else begin
        gap = $urandom_range(0, GAP_MAX);
        if ($urandom_range(0, 39) == 0) calm = $urandom_range(20, 80);
      end
      if (gap > 0) begin
        out_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!out_bus.valid);
    end
  end

  initial begin : stimulus
    stim_row_t row;
    grid_res_t scratch[2];
    int        rnd_points;
    int        sweeps;
    int        len;
    int        style;
    bit        burst;
    sample_t   u;
    sample_t   f;
    sample_t   base;
    sample_t   slope;
    logic [CFG_DATA_W-1:0] cval;
    logic [CFG_DATA_W-1:0] sval;

    rst_n           <= 1'b0;
    in_bus.valid    <= 1'b0;
    in_bus.u_sample <= '0;
    in_bus.f_sample <= '0;
    in_bus.is_last  <= 1'b0;
    cfg_bus.valid   <= 1'b0;
    cfg_bus.index   <= '0;
    cfg_bus.data    <= '0;

    courant = COURANT_RST[C_W-1:0];
    speed   = SPEED_RST[A_W-1:0];
    prev_u  = '0;
    prev_f  = '0;
    prev_hf = '0;
    pts     = PS_NONE;

    add_typed(S_MAX, S_MIN, 1'b1, 1, '{S_MAX, S_MIN, 1'b1, 1'b1}, '0);
    add_typed(S_MIN, S_MAX, 1'b0, 0, '0, '0);
    add_typed(sample_t'(123), sample_t'(-456), 1'b1, 2, '{S_MIN, S_MAX, 1'b1, 1'b0},
              '{sample_t'(123), sample_t'(-456), 1'b1, 1'b1});
    for (int k = 1; k <= 5; k++)
      add_point(sample_t'(k * 'h10000), sample_t'(k * 'h10000), k == 5);
    add_point(S_MAX, S_MIN, 1'b0);
    add_point(S_MIN, S_MAX, 1'b0);
    add_point(S_MAX, S_MAX, 1'b0);
    add_point(S_MIN, S_MIN, 1'b1);
    add_cfg(REG_COURANT, '0);
    add_point(sample_t'('h30000), sample_t'('h30000), 1'b0);
    add_point(sample_t'(-'h20000), sample_t'(-'h20000), 1'b0);
    add_point(sample_t'('h50000), sample_t'('h50000), 1'b1);
    add_cfg(REG_COURANT, COURANT_MAX);
    add_cfg(REG_SPEED, SPEED_MIN);
    add_point(32'h0001_8000, 32'hFFFF_0000, 1'b0);
    add_point(32'h7FFF_FFFF, 32'h0000_0001, 1'b0);
    add_point(32'h8000_0001, 32'h1234_5678, 1'b0);
    add_point(32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
    add_cfg(REG_SPEED, SPEED_MAX);
    add_cfg(REG_SPARE, 24'hFFFFFF);
    add_point(sample_t'(-1), sample_t'(1), 1'b0);
    add_point(sample_t'(1), sample_t'(-1), 1'b0);
    add_point(sample_t'('h10000), sample_t'(0), 1'b1);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_table[i]) begin
      row = stim_table[i];
      if (row.kind == ROW_CFG) begin
        settle();
        write_reg(row.idx, row.data);
      end else begin
        send_point(row.u, row.f, row.last, $urandom_range(0, GAP_MAX));
        if (row.typed) begin
          void'(advance_grid(row.u, row.f, row.last, scratch));
          if (row.n_typed > 0) pending_pts.push_back(row.r0);
          if (row.n_typed > 1) pending_pts.push_back(row.r1);
        end else begin
          apply_point(row.u, row.f, row.last);
        end
      end
    end

    rnd_points = 0;
    while (rnd_points < RANDOM_POINTS) begin
      settle();
      case ($urandom_range(0, 4))
        0: cval = '0;
        1: cval = COURANT_MAX;
        2, 3: cval = CFG_DATA_W'($urandom_range(0, 'h1FFFF));
        default: cval = CFG_DATA_W'($urandom);
      endcase
      case ($urandom_range(0, 4))
        0: sval = SPEED_MIN;
        1: sval = SPEED_MAX;
        2, 3: sval = CFG_DATA_W'($urandom_range(0, 'h3FFFF) - 'h20000);
        default: sval = CFG_DATA_W'($urandom);
      endcase
      write_reg(REG_COURANT, cval);
      write_reg(REG_SPEED, sval);
      if ($urandom_range(0, 7) == 0) write_reg(REG_SPARE, CFG_DATA_W'($urandom));

      burst  = ($urandom_range(0, 3) == 0);
      sweeps = $urandom_range(1, 6);
      repeat (sweeps) begin
        case ($urandom_range(0, 19))
          0: len = 1;
          1: len = 2;
          2: len = $urandom_range(25, 40);
          default: len = $urandom_range(3, 16);
        endcase
        style = $urandom_range(0, 8);
        base  = sample_t'($urandom_range(0, 'h7FFFFF)) - sample_t'('h400000);
        slope = sample_t'($urandom_range(0, 'hFFFF)) - sample_t'('h8000);
        for (int k = 0; k < len; k++) begin
          if (style < 6) begin
            u = clamp(longint'(base) + longint'(k) * longint'(slope));
            f = scale_floor(u, longint'(speed), 16);
            if (style == 5) f = clamp(longint'(f) + $urandom_range(0, 255) - 128);
          end else if (style < 8) begin
            u = sample_t'($urandom);
            f = sample_t'($urandom);
          end else begin
            u = pick_extreme();
            f = pick_extreme();
          end
          if ($urandom_range(0, 59) == 0) wait_results();
          send_point(u, f, k == len - 1, burst ? 0 : $urandom_range(0, GAP_MAX));
          apply_point(u, f, k == len - 1);
          rnd_points++;
        end
      end
    end

    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/lwa_pkg.sv
design/lwa_in_if.sv
design/lwa_out_if.sv
design/lwa_cfg_if.sv
design/lwa_ctrl.sv
design/lwa_dpath.sv
design/lax_wendroff_advection_step.sv
dv/tb_lax_wendroff_advection_step.sv
